// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; NO_ASSERTIONS removes them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/cefp_pkg.sv =====
// ---------------------------------------------------------------------------
// cefp_pkg
// Types and constants of the command and escaped frame parser.
// ---------------------------------------------------------------------------
package cefp_pkg;

  localparam int MaxNameLenDef    = 20;
  localparam int MaxFrameBytesDef = 524288;

  localparam int PtrW      = 20;
  localparam int LimW      = 21;
  localparam int NameLenW  = 5;
  localparam int NameKeep  = 5;
  localparam int AddrW     = 19;
  localparam int FifoDepth = 4;
  localparam int FifoIdxW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [PtrW-1:0] FrameBytesRst = 20'd262144;

  localparam logic [7:0] ByteNl    = 8'h0A;
  localparam logic [7:0] ByteComma = 8'h2C;
  localparam logic [7:0] ByteZero  = 8'h00;

  // Register byte address index of frame_bytes.
  localparam logic RegFrameBytes = 1'b0;

  typedef enum logic [1:0] {
    ModeCmd  = 2'd0,
    ModeDraw = 2'd1,
    ModeEsc  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    EvWrite    = 3'd0,
    EvClear    = 3'd1,
    EvCommit   = 3'd2,
    EvOverflow = 3'd3,
    EvBadEsc   = 3'd4,
    EvTooLong  = 3'd5,
    EvUnknown  = 3'd6,
    EvAbort    = 3'd7
  } ev_e;

  typedef struct packed {
    ev_e              ev;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic             last;
  } result_t;

  // Results produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== sv/cefp_cfg.sv =====
// ---------------------------------------------------------------------------
// cefp_cfg
// APB-style register port holding the frame size.
// ---------------------------------------------------------------------------
module cefp_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic [cefp_pkg::PtrW-1:0] frame_bytes_o
);
  import cefp_pkg::*;

  logic [PtrW-1:0] frame_bytes_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegFrameBytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= FrameBytesRst;
    end else if (wr_en) begin
      frame_bytes_q <= pwdata[PtrW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegFrameBytes) begin
      prdata = {{(32-PtrW){1'b0}}, frame_bytes_q};
    end
  end

  assign frame_bytes_o = frame_bytes_q;

endmodule

// ===== sv/cefp_parser.sv =====
// ---------------------------------------------------------------------------
// cefp_parser
// Parser state and the single-pass decode of one stream byte.
// ---------------------------------------------------------------------------
module cefp_parser #(
  parameter int MaxNameLen    = cefp_pkg::MaxNameLenDef,
  parameter int MaxFrameBytes = cefp_pkg::MaxFrameBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                in_byte_i,
  input  logic [cefp_pkg::PtrW-1:0] frame_bytes_i,
  output cefp_pkg::push_t           push_o
);
  import cefp_pkg::*;

  localparam logic [LimW-1:0]     MaxLim = LimW'(MaxFrameBytes);
  localparam logic [NameLenW-1:0] LenMax = NameLenW'(MaxNameLen);

  mode_e               mode_q, mode_d;
  logic [NameLenW-1:0] len_q, len_d;
  logic [7:0]          nb_q [NameKeep];
  logic [7:0]          nb_d [NameKeep];
  logic [PtrW-1:0]     wp_q, wp_d;

  logic [LimW-1:0]     limit;
  logic [PtrW-1:0]     wp_inc;
  logic [NameLenW-1:0] len_inc;
  logic                wp_full, inc_full, is_draw, do_write, clr_name;
  logic [7:0]          wr_data;
  push_t               push;

  always_comb begin
    limit = ({1'b0, frame_bytes_i} > MaxLim) ? MaxLim : {1'b0, frame_bytes_i};
  end

  assign wp_inc   = wp_q + PtrW'(1);
  assign wp_full  = {1'b0, wp_q} >= limit;
  assign inc_full = {1'b0, wp_inc} >= limit;
  assign len_inc  = len_q + NameLenW'(1);
  // Exact match of all five kept bytes, the fifth being the terminating zero.
  assign is_draw  = (nb_q[0] == 8'h64) && (nb_q[1] == 8'h72) && (nb_q[2] == 8'h61) &&
                    (nb_q[3] == 8'h77) && (nb_q[4] == ByteZero);

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    nb_d     = nb_q;
    wp_d     = wp_q;
    push     = '0;
    do_write = 1'b0;
    clr_name = 1'b0;
    wr_data  = in_byte_i;

    if (accept_i) begin
      case (mode_q)
        ModeDraw: begin
          if (wp_full) begin
            push.n     = 2'd1;
            push.r0.ev = EvOverflow;
            mode_d     = ModeCmd;
          end else if (in_byte_i == ByteNl) begin
            mode_d = ModeEsc;
          end else begin
            do_write = 1'b1;
          end
        end
        ModeEsc: begin
          if (in_byte_i == ByteNl) begin
            push.n     = 2'd1;
            push.r0.ev = EvCommit;
            mode_d     = ModeCmd;
          end else if (in_byte_i == ByteZero) begin
            do_write = 1'b1;
            wr_data  = ByteNl;
          end else begin
            push.n     = 2'd1;
            push.r0.ev = EvBadEsc;
            mode_d     = ModeCmd;
          end
        end
        default: begin
          mode_d = ModeCmd;
          if (in_byte_i == ByteNl) begin
            push.n     = 2'd1;
            push.r0.ev = EvAbort;
            clr_name   = 1'b1;
          end else if (in_byte_i == ByteComma) begin
            push.n   = 2'd1;
            clr_name = 1'b1;
            if (is_draw) begin
              push.r0.ev = EvClear;
              wp_d       = '0;
              if (limit == '0) begin
                push.n     = 2'd2;
                push.r1.ev = EvOverflow;
              end else begin
                mode_d = ModeDraw;
              end
            end else begin
              push.r0.ev = EvUnknown;
            end
          end else begin
            for (int i = 0; i < NameKeep; i++) begin
              if (len_q == NameLenW'(i)) begin
                nb_d[i] = in_byte_i;
              end
            end
            len_d = len_inc;
            if (len_inc >= LenMax) begin
              push.n     = 2'd1;
              push.r0.ev = EvTooLong;
              clr_name   = 1'b1;
            end
          end
        end
      endcase
    end

    if (do_write) begin
      push.r0.ev   = EvWrite;
      push.r0.addr = wp_q[AddrW-1:0];
      push.r0.data = wr_data;
      wp_d         = wp_inc;
      if (inc_full) begin
        push.n     = 2'd2;
        push.r1.ev = EvOverflow;
        mode_d     = ModeCmd;
      end else begin
        push.n = 2'd1;
        mode_d = ModeDraw;
      end
    end

    if (clr_name) begin
      len_d = '0;
      for (int i = 0; i < NameKeep; i++) begin
        nb_d[i] = '0;
      end
    end

    if (push.n == 2'd1) begin
      push.r0.last = 1'b1;
    end
    if (push.n == 2'd2) begin
      push.r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCmd;
      len_q  <= '0;
      wp_q   <= '0;
      for (int i = 0; i < NameKeep; i++) begin
        nb_q[i] <= '0;
      end
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      wp_q   <= wp_d;
      nb_q   <= nb_d;
    end
  end

  assign push_o = push;

endmodule

// ===== sv/cefp_out_fifo.sv =====
// ---------------------------------------------------------------------------
// cefp_out_fifo
// Small result queue taking up to two results per cycle and giving one.
// ---------------------------------------------------------------------------
module cefp_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cefp_pkg::push_t               push_i,
  input  logic                          pop_i,
  output cefp_pkg::result_t             head_o,
  output logic [cefp_pkg::FifoCntW-1:0] count_o
);
  import cefp_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoIdxW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoIdxW-1:0] wr_nxt;

  assign wr_nxt = wr_q + FifoIdxW'(1);
  assign cnt_d  = cnt_q + FifoCntW'(push_i.n) - FifoCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoIdxW'(push_i.n);
      rd_q  <= rd_q + FifoIdxW'(pop_i);
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ===== sv/command_and_escaped_frame_parser_core.sv =====
// ---------------------------------------------------------------------------
// command_and_escaped_frame_parser_core
// Byte-stream command parser with escaped frame-byte writes.
// ---------------------------------------------------------------------------
// Stream bytes arrive on in_valid_i/in_byte_i and are taken when in_stall_o
// is low. Each byte yields zero, one or two result items (event, address,
// data, last) on out_valid_o, taken when out_stall_i is low; last marks the
// final item of a byte.
// A byte's items are written to the result queue as it is taken and offered
// from the queue head in order. Throughput: one byte per cycle while each byte
// yields at most one item and out_stall_i stays low; a byte that yields two
// items takes two pops from the single output port of the four-entry queue.
// in_stall_o rises while more than two items are queued, so a byte is only
// taken when both of its possible items fit; a stalled receiver thus backs
// the input up once more than two items are queued, and nothing is dropped.
// Reset puts the parser in command mode with an empty name, the write
// pointer at zero, the queue empty and frame_bytes at 262144.
// frame_bytes is written over the APB-style port at byte address 0 and
// should only be changed while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module command_and_escaped_frame_parser_core #(
  parameter int MaxNameLen    = cefp_pkg::MaxNameLenDef,
  parameter int MaxFrameBytes = cefp_pkg::MaxFrameBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 event_res_o,
  output logic [cefp_pkg::AddrW-1:0] address_o,
  output logic [7:0]                 data_o,
  output logic                       last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cefp_pkg::*;

  logic [PtrW-1:0]     frame_bytes;
  logic                accept, pop;
  push_t               push;
  result_t             head;
  logic [FifoCntW-1:0] count;

  cefp_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frame_bytes_o (frame_bytes)
  );

  cefp_parser #(
    .MaxNameLen    (MaxNameLen),
    .MaxFrameBytes (MaxFrameBytes)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .frame_bytes_i (frame_bytes),
    .push_o        (push)
  );

  cefp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign in_stall_o  = count > FifoCntW'(FifoDepth - 2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = count != '0;
  assign pop         = out_valid_o && !out_stall_i;

  assign event_res_o = head.ev;
  assign address_o   = head.addr;
  assign data_o      = head.data;
  assign last_o      = head.last;

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count > FifoCntW'(FifoDepth),
                "result queue count beyond depth")
  `ASSERT_PROP(a_count_track, clk_i, rst_ni,
               $past(rst_ni) |-> (count == $past(count) + FifoCntW'($past(push.n))
                                  - FifoCntW'($past(pop))),
               "result queue count out of step with pushes and pops")
  `ASSERT_PROP(a_pair_queued, clk_i, rst_ni,
               (out_valid_o && !head.last) |-> (count >= FifoCntW'(2)),
               "first item of a pair offered without its partner queued")
  `ASSERT_PROP(a_no_push_stalled, clk_i, rst_ni,
               (in_stall_o || !in_valid_i) |-> (push.n == 2'd0),
               "results produced without an accepted byte")

endmodule
